[rtl/mm3_pkg.sv]
// Shared types and constants for the MurmurHash3 x64_128 hash core.
package mm3_pkg;

  // Multiplier constants of the block scramble and the final mix, and add constants of the lane mix.
  localparam logic [63:0] MulC1  = 64'h87c37b91114253d5;
  localparam logic [63:0] MulC2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] FmixM1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FmixM2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] AddH1  = 64'h0000000052dce729;
  localparam logic [63:0] AddH2  = 64'h0000000038495ab5;

  // Bytes in one full block, and the bytes carried by each 64-bit word.
  localparam logic [4:0] BlockBytes = 5'd16;
  localparam logic [4:0] WordBytes  = 5'd8;

  // A 64x64 multiply runs as three 32x32 partial products.
  localparam logic [1:0] MulLastPhase = 2'd2;

  // Operand register that feeds the multiplier and receives its result.
  typedef enum logic [1:0] {
    SRC_K1 = 2'd0,
    SRC_K2 = 2'd1,
    SRC_H1 = 2'd2,
    SRC_H2 = 2'd3
  } src_e;

  // Constant operand of the multiplier.
  typedef enum logic [1:0] {
    CST_C1 = 2'd0,
    CST_C2 = 2'd1,
    CST_M1 = 2'd2,
    CST_M2 = 2'd3
  } const_e;

  // Operation applied to the finished product before writeback.
  typedef enum logic [1:0] {
    POST_NONE  = 2'd0,
    POST_ROT31 = 2'd1,
    POST_ROT33 = 2'd2,
    POST_XSH   = 2'd3
  } post_e;

  // Lane operations outside the multiplier.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_MIX1 = 3'd1,
    OP_MIX2 = 3'd2,
    OP_TAIL = 3'd3,
    OP_FIN1 = 3'd4,
    OP_FIN2 = 3'd5,
    OP_FIN3 = 3'd6,
    OP_DONE = 3'd7
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_phase;
    src_e       mul_src;
    const_e     mul_const;
    post_e      mul_post;
    op_e        op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic full;
    logic out_free;
  } status_t;

endpackage

[rtl/mm3_ctrl.sv]
// Sequencing controller of the MurmurHash3 x64_128 hash core.
module mm3_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mm3_pkg::status_t status_i,
  output mm3_pkg::cmd_t    cmd_o
);

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_K1A  = 16'h0002,
    ST_K1B  = 16'h0004,
    ST_K2A  = 16'h0008,
    ST_K2B  = 16'h0010,
    ST_MIX1 = 16'h0020,
    ST_MIX2 = 16'h0040,
    ST_TAIL = 16'h0080,
    ST_FIN1 = 16'h0100,
    ST_FIN2 = 16'h0200,
    ST_FIN3 = 16'h0400,
    ST_F1A  = 16'h0800,
    ST_F1B  = 16'h1000,
    ST_F2A  = 16'h2000,
    ST_F2B  = 16'h4000,
    ST_DONE = 16'h8000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       phase_end;

  assign phase_end  = (phase_q == mm3_pkg::MulLastPhase);
  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d         = state_q;
    phase_d         = phase_q;
    cmd_o           = '0;
    cmd_o.mul_phase = phase_q;
    cmd_o.mul_src   = mm3_pkg::SRC_K1;
    cmd_o.mul_const = mm3_pkg::CST_C1;
    cmd_o.mul_post  = mm3_pkg::POST_NONE;
    cmd_o.op        = mm3_pkg::OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        phase_d    = '0;
        if (in_valid_i) begin
          state_d = ST_K1A;
        end
      end
      ST_K1A, ST_K1B, ST_K2A, ST_K2B, ST_F1A, ST_F1B, ST_F2A, ST_F2B: begin
        cmd_o.mul_en = 1'b1;
        phase_d      = phase_end ? 2'd0 : phase_q + 2'd1;
        unique case (state_q)
          ST_K1A: begin
            cmd_o.mul_src   = mm3_pkg::SRC_K1;
            cmd_o.mul_const = mm3_pkg::CST_C1;
            cmd_o.mul_post  = mm3_pkg::POST_ROT31;
            if (phase_end) state_d = ST_K1B;
          end
          ST_K1B: begin
            cmd_o.mul_src   = mm3_pkg::SRC_K1;
            cmd_o.mul_const = mm3_pkg::CST_C2;
            if (phase_end) state_d = ST_K2A;
          end
          ST_K2A: begin
            cmd_o.mul_src   = mm3_pkg::SRC_K2;
            cmd_o.mul_const = mm3_pkg::CST_C2;
            cmd_o.mul_post  = mm3_pkg::POST_ROT33;
            if (phase_end) state_d = ST_K2B;
          end
          ST_K2B: begin
            cmd_o.mul_src   = mm3_pkg::SRC_K2;
            cmd_o.mul_const = mm3_pkg::CST_C1;
            if (phase_end) state_d = status_i.full ? ST_MIX1 : ST_TAIL;
          end
          ST_F1A: begin
            cmd_o.mul_src   = mm3_pkg::SRC_H1;
            cmd_o.mul_const = mm3_pkg::CST_M1;
            cmd_o.mul_post  = mm3_pkg::POST_XSH;
            if (phase_end) state_d = ST_F1B;
          end
          ST_F1B: begin
            cmd_o.mul_src   = mm3_pkg::SRC_H1;
            cmd_o.mul_const = mm3_pkg::CST_M2;
            cmd_o.mul_post  = mm3_pkg::POST_XSH;
            if (phase_end) state_d = ST_F2A;
          end
          ST_F2A: begin
            cmd_o.mul_src   = mm3_pkg::SRC_H2;
            cmd_o.mul_const = mm3_pkg::CST_M1;
            cmd_o.mul_post  = mm3_pkg::POST_XSH;
            if (phase_end) state_d = ST_F2B;
          end
          default: begin
            cmd_o.mul_src   = mm3_pkg::SRC_H2;
            cmd_o.mul_const = mm3_pkg::CST_M2;
            cmd_o.mul_post  = mm3_pkg::POST_XSH;
            if (phase_end) state_d = ST_DONE;
          end
        endcase
      end
      ST_MIX1: begin
        cmd_o.op = mm3_pkg::OP_MIX1;
        state_d  = ST_MIX2;
      end
      ST_MIX2: begin
        cmd_o.op = mm3_pkg::OP_MIX2;
        state_d  = status_i.last ? ST_FIN1 : ST_IDLE;
      end
      ST_TAIL: begin
        cmd_o.op = mm3_pkg::OP_TAIL;
        state_d  = ST_FIN1;
      end
      ST_FIN1: begin
        cmd_o.op = mm3_pkg::OP_FIN1;
        state_d  = ST_FIN2;
      end
      ST_FIN2: begin
        cmd_o.op = mm3_pkg::OP_FIN2;
        state_d  = ST_FIN3;
      end
      ST_FIN3: begin
        cmd_o.op = mm3_pkg::OP_FIN3;
        state_d  = ST_F1A;
      end
      ST_DONE: begin
        // Wait until the output register can take the hash.
        if (status_i.out_free) begin
          cmd_o.op = mm3_pkg::OP_DONE;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        phase_d = '0;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

[rtl/mm3_datapath.sv]
// Lane registers, shared multiplier and output register of the hash core.
module mm3_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [63:0]      block_low_i,
  input  logic [63:0]      block_high_i,
  input  logic [4:0]       byte_count_i,
  input  logic             last_i,
  input  mm3_pkg::cmd_t    cmd_i,
  output mm3_pkg::status_t status_o,
  output logic             hash_valid_o,
  input  logic             hash_ready_i,
  output logic [63:0]      hash_value_o
);

  // Keeps the low nb bytes of a word and zeroes the rest.
  function automatic logic [63:0] keep_bytes(input logic [63:0] v, input logic [3:0] nb);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) r[i*8 +: 8] = v[i*8 +: 8];
    end
    return r;
  endfunction

  logic [63:0] k1_q, k2_q, h1_q, h2_q, len_q, prod_q, hash_q;
  logic [63:0] k1_d, k2_d, h1_d, h2_d, len_d, prod_d;
  logic        last_q, full_q, hash_valid_q;
  logic [4:0]  n_sat;
  logic [3:0]  nb_lo, nb_hi;
  logic [63:0] a_op, b_op, prod, sum, post_val;
  logic [31:0] mul_x, mul_y;
  logic [63:0] x1, t1, x2, t2, mix1, mix2, fin_a, fin_b;

  // Effective byte count of the incoming block.
  always_comb begin
    if (!last_i || byte_count_i > mm3_pkg::BlockBytes) begin
      n_sat = mm3_pkg::BlockBytes;
    end else begin
      n_sat = byte_count_i;
    end
    nb_lo = (n_sat >= mm3_pkg::WordBytes) ? 4'(mm3_pkg::WordBytes) : n_sat[3:0];
    nb_hi = (n_sat > mm3_pkg::WordBytes) ? 4'(n_sat - mm3_pkg::WordBytes) : 4'd0;
  end

  // Operand selection for the shared 32x32 multiplier.
  always_comb begin
    case (cmd_i.mul_src)
      mm3_pkg::SRC_K1: a_op = k1_q;
      mm3_pkg::SRC_K2: a_op = k2_q;
      mm3_pkg::SRC_H1: a_op = h1_q;
      default:         a_op = h2_q;
    endcase
    case (cmd_i.mul_const)
      mm3_pkg::CST_C1: b_op = mm3_pkg::MulC1;
      mm3_pkg::CST_C2: b_op = mm3_pkg::MulC2;
      mm3_pkg::CST_M1: b_op = mm3_pkg::FmixM1;
      default:         b_op = mm3_pkg::FmixM2;
    endcase
  end

  // Low half of a 64x64 product: lo*lo, then the two cross terms shifted up.
  assign mul_x = (cmd_i.mul_phase == 2'd1) ? a_op[63:32] : a_op[31:0];
  assign mul_y = (cmd_i.mul_phase == mm3_pkg::MulLastPhase) ? b_op[63:32] : b_op[31:0];
  assign prod  = {32'h0, mul_x} * {32'h0, mul_y};
  assign sum   = prod_q + {prod[31:0], 32'h0};

  // Post operation on the finished product.
  always_comb begin
    case (cmd_i.mul_post)
      mm3_pkg::POST_ROT31: post_val = {sum[32:0], sum[63:33]};
      mm3_pkg::POST_ROT33: post_val = {sum[30:0], sum[63:31]};
      mm3_pkg::POST_XSH:   post_val = sum ^ (sum >> 33);
      default:             post_val = sum;
    endcase
  end

  // Body mixing of the two lanes and the finalization arithmetic.
  assign x1    = h1_q ^ k1_q;
  assign t1    = {x1[36:0], x1[63:37]} + h2_q;
  assign mix1  = (t1 << 2) + t1 + mm3_pkg::AddH1;
  assign x2    = h2_q ^ k2_q;
  assign t2    = {x2[32:0], x2[63:33]} + h1_q;
  assign mix2  = (t2 << 2) + t2 + mm3_pkg::AddH2;
  assign fin_a = h1_q ^ len_q;
  assign fin_b = h2_q ^ len_q;

  // Next values of the working registers.
  always_comb begin
    k1_d   = k1_q;
    k2_d   = k2_q;
    h1_d   = h1_q;
    h2_d   = h2_q;
    len_d  = len_q;
    prod_d = prod_q;
    if (cmd_i.load) begin
      k1_d  = keep_bytes(block_low_i, nb_lo);
      k2_d  = keep_bytes(block_high_i, nb_hi);
      len_d = len_q + {59'h0, n_sat};
    end
    if (cmd_i.mul_en) begin
      prod_d = (cmd_i.mul_phase == 2'd0) ? prod : sum;
      if (cmd_i.mul_phase == mm3_pkg::MulLastPhase) begin
        case (cmd_i.mul_src)
          mm3_pkg::SRC_K1: k1_d = post_val;
          mm3_pkg::SRC_K2: k2_d = post_val;
          mm3_pkg::SRC_H1: h1_d = post_val;
          default:         h2_d = post_val;
        endcase
      end
    end
    case (cmd_i.op)
      mm3_pkg::OP_MIX1: h1_d = mix1;
      mm3_pkg::OP_MIX2: h2_d = mix2;
      mm3_pkg::OP_TAIL: begin
        h1_d = x1;
        h2_d = x2;
      end
      mm3_pkg::OP_FIN1: begin
        h1_d = fin_a + fin_b;
        h2_d = fin_b;
      end
      mm3_pkg::OP_FIN2: begin
        h2_d = h2_q + h1_q;
        h1_d = h1_q ^ (h1_q >> 33);
      end
      mm3_pkg::OP_FIN3: h2_d = h2_q ^ (h2_q >> 33);
      mm3_pkg::OP_DONE: begin
        h1_d  = '0;
        h2_d  = '0;
        len_d = '0;
      end
      default: ;
    endcase
  end

  // Hash state and flags of the current block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_q         <= '0;
      h2_q         <= '0;
      len_q        <= '0;
      last_q       <= 1'b0;
      full_q       <= 1'b0;
      hash_valid_q <= 1'b0;
    end else begin
      h1_q  <= h1_d;
      h2_q  <= h2_d;
      len_q <= len_d;
      if (cmd_i.load) begin
        last_q <= last_i;
        full_q <= (n_sat == mm3_pkg::BlockBytes);
      end
      if (cmd_i.op == mm3_pkg::OP_DONE) begin
        hash_valid_q <= 1'b1;
      end else if (hash_ready_i) begin
        hash_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    k1_q   <= k1_d;
    k2_q   <= k2_d;
    prod_q <= prod_d;
    if (cmd_i.op == mm3_pkg::OP_DONE) begin
      hash_q <= h1_q + h2_q;
    end
  end

  assign status_o.last     = last_q;
  assign status_o.full     = full_q;
  assign status_o.out_free = !hash_valid_q || hash_ready_i;
  assign hash_valid_o      = hash_valid_q;
  assign hash_value_o      = hash_q;

endmodule

[rtl/murmur3_x64_128_hash_core.sv]
// One 16-byte block is taken only after the last one is through; the next block is taken while a hash waits.
// Each 64-bit multiply runs on one shared 32x32 multiplier, four multiplies per block.
// A last block gives its hash after its multiplies, the lane mix (the tail step for a short tail) and finalization.
// Finalization adds three lane steps and four more multiplies on the same unit.
// Reset: asynchronous, active low; clears both lanes, the byte count and the output valid.
module murmur3_x64_128_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  input  logic [4:0]  byte_count_i,
  input  logic        last_i,
  output logic        hash_valid_o,
  input  logic        hash_ready_i,
  output logic [63:0] hash_value_o
);

  mm3_pkg::cmd_t    cmd;
  mm3_pkg::status_t status;

  // Sequencer for the block and finalization steps.
  mm3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Lanes, multiplier and output register.
  mm3_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .block_low_i  (block_low_i),
    .block_high_i (block_high_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .hash_valid_o (hash_valid_o),
    .hash_ready_i (hash_ready_i),
    .hash_value_o (hash_value_o)
  );

`ifndef NO_ASSERTIONS
  // After an input transfer the core is busy with that block.
  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("core accepted a block while the previous one was in progress");

  // The multiplier never runs while the core waits for input.
  a_mul_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.mul_en)
    else $error("multiplier active while idle");

  // A new hash only appears after the output step of the controller.
  a_hash_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hash_valid_o) |-> $past(cmd.op == mm3_pkg::OP_DONE))
    else $error("hash valid rose without a finalization");
`endif

endmodule
